// File: hdl/nvls_pkg.sv
package nvls_pkg;

    localparam int NORM_W  = 16;
    localparam int PROD_W  = 2 * NORM_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int MUL_W   = 2 * SUM_W;
    localparam int NUM_W   = MUL_W + 1;
    localparam int DEN_W   = 64;
    localparam int TOL_W   = 15;
    localparam int VEL_W   = 32;
    localparam int FRAC_SH = 22;
    localparam int QB      = VEL_W + 1;
    localparam int LANE_LAT = QB + 3;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(819);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FEW       = 2'd1,
        ST_COLLINEAR = 2'd2,
        ST_SINGULAR  = 2'd3
    } status_t;

    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic [DEN_W-1:0]         den;
        logic signed [NUM_W-1:0]  num_x;
        logic signed [NUM_W-1:0]  num_y;
    } front_t;

endpackage

// File: hdl/nvls_front.sv
module nvls_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [1:0]                        normal_count,
    input  logic signed [nvls_pkg::NORM_W-1:0] nx0,
    input  logic signed [nvls_pkg::NORM_W-1:0] ny0,
    input  logic signed [nvls_pkg::NORM_W-1:0] nx1,
    input  logic signed [nvls_pkg::NORM_W-1:0] ny1,
    input  logic signed [nvls_pkg::NORM_W-1:0] nx2,
    input  logic signed [nvls_pkg::NORM_W-1:0] ny2,
    input  logic signed [nvls_pkg::NORM_W-1:0] v0,
    input  logic signed [nvls_pkg::NORM_W-1:0] v1,
    input  logic signed [nvls_pkg::NORM_W-1:0] v2,
    input  logic [nvls_pkg::TOL_W-1:0]        tol,
    output nvls_pkg::front_t                  fr
);
    localparam int PW = nvls_pkg::PROD_W;
    localparam int SW = nvls_pkg::SUM_W;
    localparam int MW = nvls_pkg::MUL_W;
    localparam int NW = nvls_pkg::NUM_W;
    localparam int DEN_W_L = nvls_pkg::DEN_W;

    // stage 1: products
    logic [3:0] vld_reg;
    logic [1:0] cnt1_reg, cnt2_reg;
    logic signed [PW-1:0] pxx_reg [3];
    logic signed [PW-1:0] pxy_reg [3];
    logic signed [PW-1:0] pyy_reg [3];
    logic signed [PW-1:0] pxv_reg [3];
    logic signed [PW-1:0] pyv_reg [3];
    logic signed [PW-1:0] d01x_reg, d01y_reg, d12x_reg, d12y_reg;
    logic keep2;
    logic signed [nvls_pkg::NORM_W-1:0] nx2_m, ny2_m, v2_m;

    // stage 2: sums
    logic signed [SW-1:0] a_reg, b_reg, d_reg, e_reg, f_reg, dot01_reg, dot12_reg;

    // stage 3: cross products
    logic signed [MW-1:0] ad_reg, bb_reg, ed_reg, bf_reg, af_reg, eb_reg;
    nvls_pkg::status_t st3_reg, st4_reg, st3_next;
    logic near01, near12;

    logic [DEN_W_L-1:0] den4_reg;
    logic signed [NW-1:0] numx4_reg, numy4_reg;
    logic signed [MW-1:0] den_full;

    function automatic logic near_col(input logic signed [SW-1:0] dot,
                                      input logic [nvls_pkg::TOL_W-1:0] t);
        logic [SW-1:0] ad;
        logic signed [SW:0] diff;
        logic [SW:0] adiff;
        begin
            ad = dot[SW-1] ? SW'(-dot) : SW'(dot);
            diff = $signed({1'b0, ad}) - $signed((SW+1)'(1) <<< 28);
            adiff = diff[SW] ? (SW+1)'(-diff) : (SW+1)'(diff);
            near_col = adiff < (SW+1)'({t, 14'b0});
        end
    endfunction

    assign keep2 = (normal_count == 2'd3);
    // third normal only contributes when three are valid
    assign nx2_m = keep2 ? nx2 : '0;
    assign ny2_m = keep2 ? ny2 : '0;
    assign v2_m  = keep2 ? v2 : '0;
    assign near01 = near_col(dot01_reg, tol);
    assign near12 = near_col(dot12_reg, tol);

    always_comb begin
        if (cnt2_reg < 2'd2) begin
            st3_next = nvls_pkg::ST_FEW;
        end else if (cnt2_reg == 2'd2) begin
            st3_next = near01 ? nvls_pkg::ST_COLLINEAR : nvls_pkg::ST_OK;
        end else begin
            st3_next = (near01 && near12) ? nvls_pkg::ST_COLLINEAR : nvls_pkg::ST_OK;
        end
    end

    assign den_full = ad_reg - bb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cnt1_reg   <= normal_count;
            pxx_reg[0] <= nx0 * nx0;
            pxy_reg[0] <= nx0 * ny0;
            pyy_reg[0] <= ny0 * ny0;
            pxv_reg[0] <= nx0 * v0;
            pyv_reg[0] <= ny0 * v0;
            pxx_reg[1] <= nx1 * nx1;
            pxy_reg[1] <= nx1 * ny1;
            pyy_reg[1] <= ny1 * ny1;
            pxv_reg[1] <= nx1 * v1;
            pyv_reg[1] <= ny1 * v1;
            pxx_reg[2] <= nx2_m * nx2_m;
            pxy_reg[2] <= nx2_m * ny2_m;
            pyy_reg[2] <= ny2_m * ny2_m;
            pxv_reg[2] <= nx2_m * v2_m;
            pyv_reg[2] <= ny2_m * v2_m;
            d01x_reg   <= nx0 * nx1;
            d01y_reg   <= ny0 * ny1;
            d12x_reg   <= nx1 * nx2;
            d12y_reg   <= ny1 * ny2;

            cnt2_reg  <= cnt1_reg;
            a_reg     <= SW'(pxx_reg[0]) + SW'(pxx_reg[1]) + SW'(pxx_reg[2]);
            b_reg     <= SW'(pxy_reg[0]) + SW'(pxy_reg[1]) + SW'(pxy_reg[2]);
            d_reg     <= SW'(pyy_reg[0]) + SW'(pyy_reg[1]) + SW'(pyy_reg[2]);
            e_reg     <= SW'(pxv_reg[0]) + SW'(pxv_reg[1]) + SW'(pxv_reg[2]);
            f_reg     <= SW'(pyv_reg[0]) + SW'(pyv_reg[1]) + SW'(pyv_reg[2]);
            dot01_reg <= SW'(d01x_reg) + SW'(d01y_reg);
            dot12_reg <= SW'(d12x_reg) + SW'(d12y_reg);

            st3_reg <= st3_next;
            ad_reg  <= a_reg * d_reg;
            bb_reg  <= b_reg * b_reg;
            ed_reg  <= e_reg * d_reg;
            bf_reg  <= b_reg * f_reg;
            af_reg  <= a_reg * f_reg;
            eb_reg  <= e_reg * b_reg;

            st4_reg   <= st3_reg;
            den4_reg  <= den_full[DEN_W_L-1:0];
            numx4_reg <= NW'(ed_reg) - NW'(bf_reg);
            numy4_reg <= NW'(af_reg) - NW'(eb_reg);
        end
    end

    assign fr.valid  = vld_reg[3];
    assign fr.status = st4_reg;
    assign fr.den    = den4_reg;
    assign fr.num_x  = numx4_reg;
    assign fr.num_y  = numy4_reg;

endmodule

// File: hdl/nvls_lane.sv
module nvls_lane (
    input  logic                               aclk,
    input  logic                               en,
    input  logic signed [nvls_pkg::NUM_W-1:0]  num,
    input  logic [nvls_pkg::DEN_W-1:0]         den,
    output logic [nvls_pkg::VEL_W-1:0]         vel
);
    localparam int NW = nvls_pkg::NUM_W;
    localparam int DW = nvls_pkg::DEN_W;
    localparam int QB = nvls_pkg::QB;
    localparam int FW = NW + nvls_pkg::FRAC_SH;
    localparam int HW = FW - QB;

    logic          neg0_reg;
    logic [NW-1:0] mag_reg;
    logic [DW-1:0] den0_reg;

    logic [DW-1:0] rem_reg [QB+1];
    logic [DW-1:0] dd_reg  [QB+1];
    logic [QB-1:0] low_reg [QB+1];
    logic [QB-1:0] q_reg   [QB+1];
    logic          neg_reg [QB+1];
    logic          big_reg [QB+1];

    logic [FW-1:0] nfull;
    logic [HW-1:0] high;
    logic          big0;

    assign nfull = {mag_reg, {nvls_pkg::FRAC_SH{1'b0}}};
    assign high  = nfull[FW-1:QB];
    assign big0  = DW'(high) >= den0_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg0_reg <= num[NW-1];
            mag_reg  <= num[NW-1] ? NW'(-num) : NW'(num);
            den0_reg <= den;

            rem_reg[0] <= big0 ? '0 : DW'(high);
            dd_reg[0]  <= den0_reg;
            low_reg[0] <= nfull[QB-1:0];
            q_reg[0]   <= '0;
            neg_reg[0] <= neg0_reg;
            big_reg[0] <= big0;
        end
    end

    // one quotient bit per stage, high bit first
    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [DW:0] trial;
        logic [DW:0] diff;
        logic        ge;
        assign trial = {rem_reg[j], low_reg[j][QB-1]};
        assign ge    = trial >= {1'b0, dd_reg[j]};
        assign diff  = trial - {1'b0, dd_reg[j]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
                q_reg[j+1]   <= {q_reg[j][QB-2:0], ge};
                low_reg[j+1] <= low_reg[j] << 1;
                dd_reg[j+1]  <= dd_reg[j];
                neg_reg[j+1] <= neg_reg[j];
                big_reg[j+1] <= big_reg[j];
            end
        end
    end

    logic [QB-1:0] qf;
    assign qf = q_reg[QB];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (neg_reg[QB]) begin
                if (big_reg[QB] || qf > QB'(33'h0_8000_0000)) begin
                    vel <= {1'b1, {(nvls_pkg::VEL_W-1){1'b0}}};
                end else begin
                    vel <= nvls_pkg::VEL_W'(-qf);
                end
            end else begin
                if (big_reg[QB] || qf > QB'(33'h0_7FFF_FFFF)) begin
                    vel <= {1'b0, {(nvls_pkg::VEL_W-1){1'b1}}};
                end else begin
                    vel <= qf[nvls_pkg::VEL_W-1:0];
                end
            end
        end
    end

endmodule

// File: hdl/normal_velocity_least_squares.sv
// throughput: one beat per cycle while s_ready is high; 4 front stages of products and sums, then two
//   divider lanes of 36 stages each (33 of them one quotient bit apiece) and an output register
// a skid register behind the output lets the pipeline drain one beat into it on stall
// aresetn (synchronous, active low) clears valid flags and loads collinear_tolerance to 819
module normal_velocity_least_squares (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_normal_count,
    input  logic signed [15:0] s_normal0_x,
    input  logic signed [15:0] s_normal0_y,
    input  logic signed [15:0] s_normal1_x,
    input  logic signed [15:0] s_normal1_y,
    input  logic signed [15:0] s_normal2_x,
    input  logic signed [15:0] s_normal2_y,
    input  logic signed [15:0] s_speed0,
    input  logic signed [15:0] s_speed1,
    input  logic signed [15:0] s_speed2,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic [1:0]         m_status
);
    localparam int LAT = nvls_pkg::LANE_LAT;

    logic [nvls_pkg::TOL_W-1:0] tol_reg;
    logic en;
    nvls_pkg::front_t fr;
    logic [31:0] lane_x, lane_y;

    logic              sb_vld_reg [LAT];
    nvls_pkg::status_t sb_st_reg  [LAT];

    logic              skid_valid_reg;
    logic [31:0]       skid_x_reg, skid_y_reg;
    nvls_pkg::status_t skid_st_reg;
    logic [31:0]       pipe_x, pipe_y;
    nvls_pkg::status_t pipe_st;
    logic              pipe_vld;

    assign cfg_ready = 1'b1;
    assign en        = !skid_valid_reg;
    assign s_ready   = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= nvls_pkg::TOL_RESET;
        end else if (cfg_valid) begin
            tol_reg <= cfg_data;
        end
    end

    nvls_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid),
        .normal_count (s_normal_count),
        .nx0          (s_normal0_x),
        .ny0          (s_normal0_y),
        .nx1          (s_normal1_x),
        .ny1          (s_normal1_y),
        .nx2          (s_normal2_x),
        .ny2          (s_normal2_y),
        .v0           (s_speed0),
        .v1           (s_speed1),
        .v2           (s_speed2),
        .tol          (tol_reg),
        .fr           (fr)
    );

    nvls_lane u_lane_x (
        .aclk (aclk),
        .en   (en),
        .num  (fr.num_x),
        .den  (fr.den),
        .vel  (lane_x)
    );

    nvls_lane u_lane_y (
        .aclk (aclk),
        .en   (en),
        .num  (fr.num_y),
        .den  (fr.den),
        .vel  (lane_y)
    );

    // sideband runs alongside the lanes; singular check folds in at entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LAT; i++) sb_vld_reg[i] <= 1'b0;
        end else if (en) begin
            sb_vld_reg[0] <= fr.valid;
            for (int i = 1; i < LAT; i++) sb_vld_reg[i] <= sb_vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sb_st_reg[0] <= (fr.status == nvls_pkg::ST_OK && fr.den == '0)
                            ? nvls_pkg::ST_SINGULAR : fr.status;
            for (int i = 1; i < LAT; i++) sb_st_reg[i] <= sb_st_reg[i-1];
        end
    end

    // merge: lanes give the values, sideband decides whether they count
    assign pipe_vld = sb_vld_reg[LAT-1] && en;
    assign pipe_st  = sb_st_reg[LAT-1];
    assign pipe_x   = (pipe_st == nvls_pkg::ST_OK) ? lane_x : '0;
    assign pipe_y   = (pipe_st == nvls_pkg::ST_OK) ? lane_y : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid        <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid || m_ready) begin
            m_valid        <= skid_valid_reg || pipe_vld;
            skid_valid_reg <= 1'b0;
        end else if (pipe_vld) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid || m_ready) begin
            if (skid_valid_reg) begin
                m_vel_x  <= skid_x_reg;
                m_vel_y  <= skid_y_reg;
                m_status <= skid_st_reg;
            end else begin
                m_vel_x  <= pipe_x;
                m_vel_y  <= pipe_y;
                m_status <= pipe_st;
            end
        end else if (pipe_vld) begin
            skid_x_reg  <= pipe_x;
            skid_y_reg  <= pipe_y;
            skid_st_reg <= pipe_st;
        end
    end

    a_skid_needs_full_out : assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid)
        else $error("skid holds a beat while output is empty");

    a_stall_fills_skid : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && pipe_vld) |=> skid_valid_reg)
        else $error("beat leaving the pipeline was dropped");

    a_fail_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != nvls_pkg::ST_OK) |-> (m_vel_x == '0 && m_vel_y == '0))
        else $error("failed result carries a nonzero velocity");

endmodule
